>>> rtl/core/shelf_atlas_placer_unit_macros.svh
// Assertion macros shared by the shelf atlas placer RTL.
// Depends on nothing; the asserting modules provide clk and arst_n.
`ifndef SHELF_ATLAS_PLACER_UNIT_MACROS_SVH
`define SHELF_ATLAS_PLACER_UNIT_MACROS_SVH
`ifndef SYNTH
`define SAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SAP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define SAP_ASSERT(lbl, prop, msg)
`define SAP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/core/sap_pkg.sv
// Package for the shelf atlas placer: widths, codes, types and defaults.
// Used by the interfaces, the table, the shelf cursor and the top level.
package sap_pkg;

	localparam int DIM_W         = 13;
	localparam int ID_W          = 32;
	localparam int STATUS_W      = 2;
	localparam int CFG_IDX_W     = 4;
	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_DIMENSION = 4096;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIMENSION);
	localparam logic [DIM_W-1:0] DIM_SAT   = {DIM_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

	localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_FULL     = STATUS_W'(2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DIM_W-1:0] y;
		logic [DIM_W-1:0] x;
	} entry_t;

	typedef struct packed {
		logic [DIM_W-1:0] x;
		logic [DIM_W-1:0] y;
		logic             overflow;
	} place_t;

endpackage

>>> rtl/core/sap_ifs.sv
// Valid/ready channel interfaces of the shelf atlas placer: request, result, config.
// Depends on sap_pkg for field widths.
interface sap_req_if;
	logic                         valid;
	logic                         ready;
	logic [sap_pkg::ID_W-1:0]     image_id;
	logic [sap_pkg::DIM_W-1:0]    image_width;
	logic [sap_pkg::DIM_W-1:0]    image_height;
	modport source (output valid, image_id, image_width, image_height, input ready);
	modport sink (input valid, image_id, image_width, image_height, output ready);
endinterface

interface sap_res_if;
	logic                          valid;
	logic                          ready;
	logic [sap_pkg::DIM_W-1:0]     place_x;
	logic [sap_pkg::DIM_W-1:0]     place_y;
	logic                          already_present;
	logic [sap_pkg::STATUS_W-1:0]  status;
	modport source (output valid, place_x, place_y, already_present, status, input ready);
	modport sink (input valid, place_x, place_y, already_present, status, output ready);
endinterface

interface sap_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sap_pkg::CFG_IDX_W-1:0]  index;
	logic [sap_pkg::DIM_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/sap_table.sv
// Id/position table of the shelf atlas placer: one write port, one registered read port.
// Depends on sap_pkg for the entry type.
module sap_table #(
	parameter int TABLE_ENTRIES = sap_pkg::TABLE_ENTRIES,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  sap_pkg::entry_t       wr_entry,
	input  logic [IDX_W-1:0]      rd_addr,
	output sap_pkg::entry_t       rd_entry
);

	sap_pkg::entry_t mem [TABLE_ENTRIES];
	sap_pkg::entry_t rd_entry_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		rd_entry_q <= mem[rd_addr];
	end

	assign rd_entry = rd_entry_q;

endmodule

>>> rtl/core/sap_shelf.sv
// Shelf cursor of the shelf atlas placer: cursor and row height registers and the
// placement of the next new image. Depends on sap_pkg.
module sap_shelf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sap_pkg::DIM_W-1:0]  atlas_width,
	input  logic [sap_pkg::DIM_W-1:0]  atlas_height,
	input  logic [sap_pkg::DIM_W-1:0]  image_width,
	input  logic [sap_pkg::DIM_W-1:0]  image_height,
	input  logic                       commit,
	output sap_pkg::place_t            place
);

	logic [sap_pkg::DIM_W-1:0] cursor_x_q;
	logic [sap_pkg::DIM_W-1:0] cursor_y_q;
	logic [sap_pkg::DIM_W-1:0] shelf_height_q;

	logic [sap_pkg::DIM_W:0]   x_end;
	logic [sap_pkg::DIM_W:0]   row_start;
	logic                      wrap;
	logic [sap_pkg::DIM_W-1:0] nx;
	logic [sap_pkg::DIM_W-1:0] ny;
	logic [sap_pkg::DIM_W-1:0] nh;
	logic [sap_pkg::DIM_W:0]   next_end;

	always_comb begin
		x_end     = {1'b0, cursor_x_q} + {1'b0, image_width};
		row_start = {1'b0, cursor_y_q} + {1'b0, shelf_height_q};
		wrap      = x_end > {1'b0, atlas_width};
		nx        = wrap ? '0 : cursor_x_q;
		ny        = wrap ? row_start[sap_pkg::DIM_W-1:0] : cursor_y_q;
		nh        = wrap ? '0 : shelf_height_q;
		next_end  = {1'b0, nx} + {1'b0, image_width};
		place.x        = nx;
		place.y        = ny;
		place.overflow = wrap && (row_start >= {1'b0, atlas_height});
	end

	// The cursor moves past the image, from x 0 on a wrap, and saturates at the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			shelf_height_q <= '0;
		end else if (commit) begin
			cursor_x_q     <= next_end[sap_pkg::DIM_W] ? sap_pkg::DIM_SAT
			                                           : next_end[sap_pkg::DIM_W-1:0];
			cursor_y_q     <= ny;
			shelf_height_q <= (nh > image_height) ? nh : image_height;
		end
	end

endmodule

>>> rtl/core/shelf_atlas_placer_unit.sv
// Top level of the shelf atlas placer: control sequencer, config registers, result register.
// Depends on sap_pkg, sap_ifs, sap_table, sap_shelf and the assertion macro header.
//
// The placer packs images onto horizontal shelves of a texture atlas and remembers where
// each image id went. One request beat carries an id, a width and a height; exactly one
// result beat comes back with the position, a flag that says the id was already known,
// and a status (ok, atlas height overflow, or id table full). The block handles one
// request at a time. The id table is a synchronous memory with one write port and one
// registered read port. It is scanned one entry per cycle, with the read of the next
// entry overlapping the compare of the previous one. A hit ends the scan early. After
// a miss the PLACE state computes the placement and records it unless the table is full
// or the atlas overflows; the FINISH state then loads the result register. The result
// register decouples the two sides:
// the block goes back to accepting requests as soon as a result has been loaded there,
// and it only waits at the end of the next request if that result is still not taken.
// The table needs no clearing pass after reset, since only entries below the fill count
// are ever compared. Configuration writes (atlas width and height) are always accepted
// and should be made while no request is in flight.
`include "shelf_atlas_placer_unit_macros.svh"

module shelf_atlas_placer_unit #(
	parameter int TABLE_ENTRIES = sap_pkg::TABLE_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	sap_req_if.sink       req,
	sap_res_if.source     res,
	sap_cfg_if.sink       cfg
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	// Configuration registers.
	logic [sap_pkg::DIM_W-1:0] atlas_width_q;
	logic [sap_pkg::DIM_W-1:0] atlas_height_q;

	// Sequencer state and the request being worked on.
	sap_pkg::state_t           state_q;
	sap_pkg::state_t           state_n;
	logic [sap_pkg::ID_W-1:0]  item_id_q;
	logic [sap_pkg::DIM_W-1:0] item_w_q;
	logic [sap_pkg::DIM_W-1:0] item_h_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          scan_idx_q;
	logic                      rd_vld_s1;

	// Finished result waiting for the output register.
	logic [sap_pkg::DIM_W-1:0]    pend_x_q;
	logic [sap_pkg::DIM_W-1:0]    pend_y_q;
	logic                         pend_present_q;
	logic [sap_pkg::STATUS_W-1:0] pend_status_q;

	// Output register.
	logic                         res_valid_q;
	logic [sap_pkg::DIM_W-1:0]    res_x_q;
	logic [sap_pkg::DIM_W-1:0]    res_y_q;
	logic                         res_present_q;
	logic [sap_pkg::STATUS_W-1:0] res_status_q;

	logic                 accept;
	logic                 issue;
	logic                 hit;
	logic                 scan_done;
	logic                 tbl_full;
	logic                 tbl_wr;
	logic                 load_hit;
	logic                 load_place;
	logic                 load_out;
	sap_pkg::entry_t      wr_entry;
	sap_pkg::entry_t      rd_entry;
	sap_pkg::place_t      place;

	sap_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk      (clk),
		.wr_en    (tbl_wr),
		.wr_addr  (count_q[IDX_W-1:0]),
		.wr_entry (wr_entry),
		.rd_addr  (scan_idx_q[IDX_W-1:0]),
		.rd_entry (rd_entry)
	);

	sap_shelf u_shelf (
		.clk          (clk),
		.arst_n       (arst_n),
		.atlas_width  (atlas_width_q),
		.atlas_height (atlas_height_q),
		.image_width  (item_w_q),
		.image_height (item_h_q),
		.commit       (tbl_wr),
		.place        (place)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == sap_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;

	// A read is issued for each entry below the fill count; its data is compared in the next
	// cycle. The table is never written during a scan, so reads and writes cannot collide.
	assign issue     = (state_q == sap_pkg::ST_SCAN) && (scan_idx_q < count_q);
	assign hit       = rd_vld_s1 && (rd_entry.id == item_id_q);
	assign scan_done = !issue && !rd_vld_s1;
	assign tbl_full  = (count_q == CNT_FULL);

	assign wr_entry.id = item_id_q;
	assign wr_entry.x  = place.x;
	assign wr_entry.y  = place.y;

	always_comb begin
		state_n    = state_q;
		load_hit   = 1'b0;
		load_place = 1'b0;
		load_out   = 1'b0;
		tbl_wr     = 1'b0;
		case (state_q)
			sap_pkg::ST_IDLE: begin
				if (accept) begin
					state_n = sap_pkg::ST_SCAN;
				end
			end
			sap_pkg::ST_SCAN: begin
				if (hit) begin
					load_hit = 1'b1;
					state_n  = sap_pkg::ST_FINISH;
				end else if (scan_done) begin
					state_n = sap_pkg::ST_PLACE;
				end
			end
			sap_pkg::ST_PLACE: begin
				load_place = 1'b1;
				tbl_wr     = !tbl_full && !place.overflow;
				state_n    = sap_pkg::ST_FINISH;
			end
			sap_pkg::ST_FINISH: begin
				if (!res_valid_q || res.ready) begin
					load_out = 1'b1;
					state_n  = sap_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = sap_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sap_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= sap_pkg::DIM_RESET;
			atlas_height_q <= sap_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == sap_pkg::REG_ATLAS_WIDTH) begin
				atlas_width_q <= cfg.data;
			end else if (cfg.index == sap_pkg::REG_ATLAS_HEIGHT) begin
				atlas_height_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !hit;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (tbl_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_id_q <= req.image_id;
			item_w_q  <= req.image_width;
			item_h_q  <= req.image_height;
		end
		if (load_hit) begin
			pend_x_q       <= rd_entry.x;
			pend_y_q       <= rd_entry.y;
			pend_present_q <= 1'b1;
			pend_status_q  <= sap_pkg::STATUS_OK;
		end else if (load_place) begin
			pend_present_q <= 1'b0;
			if (tbl_full) begin
				pend_x_q      <= '0;
				pend_y_q      <= '0;
				pend_status_q <= sap_pkg::STATUS_FULL;
			end else if (place.overflow) begin
				pend_x_q      <= '0;
				pend_y_q      <= '0;
				pend_status_q <= sap_pkg::STATUS_OVERFLOW;
			end else begin
				pend_x_q      <= place.x;
				pend_y_q      <= place.y;
				pend_status_q <= sap_pkg::STATUS_OK;
			end
		end
		if (load_out) begin
			res_x_q       <= pend_x_q;
			res_y_q       <= pend_y_q;
			res_present_q <= pend_present_q;
			res_status_q  <= pend_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.place_x         = res_x_q;
	assign res.place_y         = res_y_q;
	assign res.already_present = res_present_q;
	assign res.status          = res_status_q;

	`SAP_ASSERT(a_count_bound, count_q <= CNT_FULL, "fill count passed table size")
	`SAP_ASSERT(a_wr_in_place, !tbl_wr || (state_q == sap_pkg::ST_PLACE && !tbl_full), "bad write")
	`SAP_ASSERT_NEXT(a_wr_count, tbl_wr, count_q == $past(count_q) + CNT_W'(1), "count not advanced")
	`SAP_ASSERT(a_rd_in_scan, !rd_vld_s1 || state_q == sap_pkg::ST_SCAN, "compare outside scan")
	`SAP_ASSERT_NEXT(a_out_load, load_out, res_valid_q && res_status_q == $past(pend_status_q), "no load")

endmodule
